// ===== src/hpbi_pkg.sv =====
// Shared types and constants of the half-pel bilinear interpolator.
package hpbi_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int PIX_W       = 8;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 12;
    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int GROUPS      = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Reset values and clamp limits of the frame size
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd176;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd144;
    localparam logic [CFG_W-1:0] SIZE_MIN     = 12'd2;
    localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);

    // Bit positions of the group mask, in emission order
    localparam int GRP_UP_LEFT   = 0; // (x-1, y-1)
    localparam int GRP_UP        = 1; // (x,   y-1), last column
    localparam int GRP_LEFT      = 2; // (x-1, y),   last row
    localparam int GRP_CORNER    = 3; // (x,   y),   last row and column

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [GROUPS-1:0] mask_t;

    // One classified pixel with the neighbors its groups need
    typedef struct packed {
        pix_t  pixel;
        pix_t  above;
        pix_t  left;
        pix_t  up_left;
        col_t  x;
        row_t  y;
        mask_t mask;
    } entry_t;

    // Queue status seen by the front part
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              not_empty;
    } queue_status_t;

endpackage

// ===== src/hpbi_ifs.sv =====
// Valid/ready channel interfaces for source pixels and output groups.
interface hpbi_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [hpbi_pkg::PIX_W-1:0] pixel;
    logic                      frame_start;

    modport source(output valid, output pixel, output frame_start, input ready);
    modport sink(input valid, input pixel, input frame_start, output ready);
endinterface

interface hpbi_group_if;
    logic                      valid;
    logic                      ready;
    logic [hpbi_pkg::PIX_W-1:0] out_top_left;
    logic [hpbi_pkg::PIX_W-1:0] out_top_right;
    logic [hpbi_pkg::PIX_W-1:0] out_bottom_left;
    logic [hpbi_pkg::PIX_W-1:0] out_bottom_right;
    logic [hpbi_pkg::COL_W-1:0] group_x;
    logic [hpbi_pkg::ROW_W-1:0] group_y;
    logic                      last_of_input;
    logic                      frame_done;

    modport source(output valid, output out_top_left, output out_top_right,
                   output out_bottom_left, output out_bottom_right, output group_x,
                   output group_y, output last_of_input, output frame_done,
                   input ready);
    modport sink(input valid, input out_top_left, input out_top_right,
                 input out_bottom_left, input out_bottom_right, input group_x,
                 input group_y, input last_of_input, input frame_done,
                 output ready);
endinterface

// ===== src/hpbi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hpbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same address is written
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ===== src/hpbi_front.sv =====
// Front part: frame size registers, position counters, line buffer, classification.
module hpbi_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [hpbi_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hpbi_pkg::CFG_W-1:0]        cfg_wr_data,
    hpbi_pixel_if.sink                        pixels,
    input  hpbi_pkg::queue_status_t           q_status,
    output logic                              push,
    output hpbi_pkg::entry_t                  push_entry
);
    import hpbi_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    col_t             col_reg;
    col_t             col_next;
    row_t             row_reg;
    row_t             row_next;

    logic             s1_valid_reg;
    pix_t             s1_pixel_reg;
    col_t             s1_x_reg;
    row_t             s1_y_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;
    pix_t             left_reg;
    pix_t             up_left_reg;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    col_t             x_cur;
    row_t             y_cur;
    logic [CFG_W:0]   x_inc;
    logic [ROW_W:0]   y_inc;
    logic             last_col;
    logic             last_row;
    logic             accept;
    logic [QCNT_W:0]  in_flight;
    pix_t             above;
    mask_t            mask;

    // Hold a slot in the queue for every transaction that may still arrive
    assign in_flight    = {1'b0, q_status.count} + (QCNT_W + 1)'(s1_valid_reg);
    assign pixels.ready = in_flight < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept       = pixels.valid && pixels.ready;

    // Clamp the frame size and locate the incoming pixel
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < SIZE_MIN)
        begin
            w_eff = SIZE_MIN;
        end
        else if (width_reg > WIDTH_MAX)
        begin
            w_eff = WIDTH_MAX;
        end
        h_eff = (height_reg < SIZE_MIN) ? SIZE_MIN : height_reg;

        x_cur    = pixels.frame_start ? '0 : col_reg;
        y_cur    = pixels.frame_start ? '0 : row_reg;
        last_col = {1'b0, x_cur} == (w_eff - CFG_W'(1));
        last_row = y_cur == (h_eff - CFG_W'(1));

        // Advance the counters, wrapping at row and frame end
        x_inc    = (CFG_W + 1)'(x_cur) + (CFG_W + 1)'(1);
        y_inc    = (ROW_W + 1)'(y_cur) + (ROW_W + 1)'(1);
        col_next = x_inc[COL_W-1:0];
        row_next = y_cur;
        if (x_inc >= {1'b0, w_eff})
        begin
            col_next = '0;
            row_next = (y_inc >= {1'b0, h_eff}) ? '0 : y_inc[ROW_W-1:0];
        end
    end

    // Line buffer: read the pixel above and replace it in the same cycle
    hpbi_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (x_cur),
        .wr_data (pixels.pixel),
        .rd_en   (accept),
        .rd_addr (x_cur),
        .rd_data (above)
    );

    // Decide which groups this pixel releases
    always_comb
    begin
        mask              = '0;
        mask[GRP_UP_LEFT] = (s1_y_reg != '0) && (s1_x_reg != '0);
        mask[GRP_UP]      = (s1_y_reg != '0) && s1_last_col_reg;
        mask[GRP_LEFT]    = s1_last_row_reg && (s1_x_reg != '0);
        mask[GRP_CORNER]  = s1_last_row_reg && s1_last_col_reg;

        push_entry.pixel   = s1_pixel_reg;
        push_entry.above   = above;
        push_entry.left    = left_reg;
        push_entry.up_left = up_left_reg;
        push_entry.x       = s1_x_reg;
        push_entry.y       = s1_y_reg;
        push_entry.mask    = mask;
    end

    // Drop pixels that release nothing
    assign push = s1_valid_reg && (mask != '0);

    // Control state: size registers, counters, stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
            up_left_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                left_reg    <= s1_pixel_reg;
                up_left_reg <= above;
            end
        end
    end

    // Payload of the classification stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= pixels.pixel;
            s1_x_reg        <= x_cur;
            s1_y_reg        <= y_cur;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

endmodule

// ===== src/hpbi_queue.sv =====
// Short FIFO of classified pixels between the front and back parts.
module hpbi_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hpbi_pkg::entry_t         push_entry,
    input  logic                     pop,
    output hpbi_pkg::entry_t         head,
    output hpbi_pkg::queue_status_t  status
);
    import hpbi_pkg::*;

    entry_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head             = slots[rd_ptr_reg];
    assign status.count     = count_reg;
    assign status.not_empty = count_reg != '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/hpbi_back.sv =====
// Back part: expands each queued pixel into its groups and computes the averages.
module hpbi_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hpbi_pkg::entry_t         head,
    input  hpbi_pkg::queue_status_t  q_status,
    output logic                     pop,
    hpbi_group_if.source             groups
);
    import hpbi_pkg::*;

    logic   work_valid_reg;
    entry_t work_reg;
    mask_t  work_mask_reg;
    mask_t  rest;
    logic   emit;

    logic   out_valid_reg;
    pix_t   tl_reg;
    pix_t   tr_reg;
    pix_t   bl_reg;
    pix_t   br_reg;
    col_t   gx_reg;
    row_t   gy_reg;
    logic   last_reg;
    logic   done_reg;

    pix_t   a;
    pix_t   b;
    pix_t   c;
    pix_t   d;
    col_t   gx;
    row_t   gy;
    logic   done;
    logic [PIX_W:0]   sum_tr;
    logic [PIX_W:0]   sum_bl;
    logic [PIX_W+1:0] sum_br;

    assign emit = work_valid_reg && (!out_valid_reg || groups.ready);
    assign rest = work_mask_reg & (work_mask_reg - mask_t'(1));
    assign pop  = q_status.not_empty && (!work_valid_reg || (emit && (rest == '0)));

    // Pick the earliest pending group and its corner samples
    always_comb
    begin
        a    = work_reg.pixel;
        b    = work_reg.pixel;
        c    = work_reg.pixel;
        d    = work_reg.pixel;
        gx   = work_reg.x;
        gy   = work_reg.y;
        done = 1'b0;
        priority if (work_mask_reg[GRP_UP_LEFT])
        begin
            a  = work_reg.up_left;
            b  = work_reg.above;
            c  = work_reg.left;
            gx = work_reg.x - col_t'(1);
            gy = work_reg.y - row_t'(1);
        end
        else if (work_mask_reg[GRP_UP])
        begin
            a  = work_reg.above;
            b  = work_reg.above;
            gy = work_reg.y - row_t'(1);
        end
        else if (work_mask_reg[GRP_LEFT])
        begin
            a  = work_reg.left;
            c  = work_reg.left;
            gx = work_reg.x - col_t'(1);
        end
        else
        begin
            done = 1'b1;
        end

        sum_tr = (PIX_W + 1)'(a) + (PIX_W + 1)'(b) + (PIX_W + 1)'(1);
        sum_bl = (PIX_W + 1)'(a) + (PIX_W + 1)'(c) + (PIX_W + 1)'(1);
        sum_br = (PIX_W + 2)'(a) + (PIX_W + 2)'(b) + (PIX_W + 2)'(c)
               + (PIX_W + 2)'(d) + (PIX_W + 2)'(2);
    end

    // Control: work register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                work_valid_reg <= 1'b1;
            end
            else if (emit && (rest == '0))
            begin
                work_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (groups.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load a new entry, retire groups, register the result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg      <= head;
            work_mask_reg <= head.mask;
        end
        else if (emit)
        begin
            work_mask_reg <= rest;
        end
        if (emit)
        begin
            tl_reg   <= a;
            tr_reg   <= sum_tr[PIX_W:1];
            bl_reg   <= sum_bl[PIX_W:1];
            br_reg   <= sum_br[PIX_W+1:2];
            gx_reg   <= gx;
            gy_reg   <= gy;
            last_reg <= rest == '0;
            done_reg <= done;
        end
    end

    assign groups.valid            = out_valid_reg;
    assign groups.out_top_left     = tl_reg;
    assign groups.out_top_right    = tr_reg;
    assign groups.out_bottom_left  = bl_reg;
    assign groups.out_bottom_right = br_reg;
    assign groups.group_x          = gx_reg;
    assign groups.group_y          = gy_reg;
    assign groups.last_of_input    = last_reg;
    assign groups.frame_done       = done_reg;

endmodule

// ===== src/half_pel_bilinear_interpolator_top.sv =====
// Half-pel bilinear interpolator top level: 8-bit luma pixels in raster order go in,
// one 2x2 half-pel group per source pixel comes out, each group released once its right
// and lower neighbors have arrived. The block takes one pixel per cycle while the queue
// has room; a pixel is located and reads the line buffer as it is accepted, is classified
// in the front part's stage register, waits in a four-entry queue, and the back part
// emits one group per cycle into an output register while that register is empty or taken.
// Output is limited to one group per cycle: pixels in the last column release two groups
// and those in the last row up to four, so input stalls at row ends and along the last
// row once the queue fills. The line buffer is a 2048-entry RAM with no clearing pass;
// the entries read in the first row of a frame are never used by any group. Write
// image_width and image_height only while the block is idle; raise frame_start on the
// first pixel of a frame.
module half_pel_bilinear_interpolator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hpbi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hpbi_pkg::CFG_W-1:0]       cfg_wr_data,
    hpbi_pixel_if.sink                       pixels,
    hpbi_group_if.source                     groups
);
    import hpbi_pkg::*;

    logic          push;
    logic          pop;
    entry_t        push_entry;
    entry_t        head;
    queue_status_t q_status;

    hpbi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .pixels      (pixels),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    hpbi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    hpbi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .groups   (groups)
    );

    // Queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

    // Every push finds a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (q_status.count < QCNT_W'(QUEUE_DEPTH)))
    else $error("push into a full queue");

    // Pop only from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.not_empty)
    else $error("pop from an empty queue");

    // The corner group is always the last one of its pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (groups.valid && groups.frame_done) |-> groups.last_of_input)
    else $error("frame_done group not last of its transaction");

endmodule
